### rtl/vbpc_pkg.sv
// Shared types, widths, constants and the exp lookup table for the
// value-to-bin population coder. No dependencies.
`default_nettype none

package vbpc_pkg;

    localparam int NUM_BINS        = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_SPAN        = 16;

    localparam int NB_W   = $clog2(NUM_BINS + 1);
    localparam int OFF_W  = 16;
    localparam int NP_W   = OFF_W + NB_W;
    localparam int AM_W   = NP_W + 1;
    localparam int M_W    = AM_W + 1;
    localparam int SIG_W  = 12;
    localparam int DEN_W  = SIG_W + 16;
    localparam int ZQ_W   = 15;
    localparam int REM_W  = DEN_W + ZQ_W;
    localparam int ZQ2_W  = 2 * ZQ_W;
    localparam int FRAC_SHIFT = 19;
    localparam int K_SHIFT    = 29;
    localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH);
    localparam int DEP_W  = TAB_AW + 1;
    localparam int P_W    = ZQ2_W + DEP_W;
    localparam int K_W    = P_W - K_SHIFT;
    localparam int CMP_W  = (AM_W + 7 > DEN_W + 3) ? AM_W + 7 : DEN_W + 3;
    localparam int QDEPTH = 2;

    localparam logic signed [15:0] ONE_Q14     = 16'sh4000;
    localparam logic signed [15:0] NEG_ONE_Q14 = -16'sh4000;

    // config register indexes
    localparam logic [2:0] REG_BIN_MIN   = 3'd0;
    localparam logic [2:0] REG_BIN_MAX   = 3'd1;
    localparam logic [2:0] REG_NUM_BINS  = 3'd2;
    localparam logic [2:0] REG_BIN_SIGMA = 3'd3;
    localparam logic [2:0] REG_ZERO_NEG  = 3'd4;
    localparam logic [2:0] REG_ZERO_DCR  = 3'd5;

    // per-sample coding mode
    localparam logic [1:0] MODE_OUT   = 2'd0;
    localparam logic [1:0] MODE_HOT   = 2'd1;
    localparam logic [1:0] MODE_ZERO  = 2'd2;
    localparam logic [1:0] MODE_GAUSS = 2'd3;

    typedef struct packed {
        logic signed [15:0] bin_min;
        logic signed [15:0] bin_max;
        logic [4:0]         num_bins;
        logic [SIG_W-1:0]   bin_sigma;
        logic               zero_neg;
        logic               zero_dcr;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [NB_W-1:0]       hot;
        logic signed [M_W-1:0] m0;
    } q_entry_t;

    typedef struct packed {
        logic [1:0] sel;
        logic [3:0] bin;
        logic       last;
    } div_tag_t;

    typedef logic [EXP_TABLE_DEPTH-1:0][15:0] exp_tab_t;

    function automatic logic [NB_W-1:0] n_eff(input logic [4:0] x);
        logic [NB_W-1:0] r;
        if (x == 5'd0)
            r = NB_W'(1);
        else if (int'(x) > NUM_BINS)
            r = NB_W'(NUM_BINS);
        else
            r = NB_W'(x);
        return r;
    endfunction

    // geometric series of exp(-EXP_SPAN/DEPTH) in Q31, rounded to Q1.14
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t           tab;
        logic [63:0]        y;
        logic [63:0]        term;
        logic [63:0]        v;
        logic [63:0]        r;
        logic signed [63:0] sum;
        y    = (64'(EXP_SPAN) << 31) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 31;
        sum  = $signed(term);
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * y) >> 31) / 64'(k);
            if ((k & 1) != 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        r = sum;
        v = 64'd1 << 31;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            tab[i] = 16'((v + (64'd1 << 16)) >> 17);
            v = (v * r + (64'd1 << 30)) >> 31;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

### rtl/vbpc_front.sv
// Front end: buffers one sample, clamps it, classifies the coding mode and
// works out the one-hot bin and the first bin's distance term. Uses vbpc_pkg.
`default_nettype none

module vbpc_front import vbpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        push,
    output q_entry_t    push_entry,
    input  logic        full
);

    localparam int CNT_W = $clog2(NB_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_M0   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic signed [15:0]    hold_sample_reg;
    logic signed [15:0]    v_reg;
    logic                  dcr_reg;
    logic [1:0]            mode_reg;
    logic [15:0]           range_u_reg;
    logic                  range_pos_reg;
    logic [NB_W-1:0]       n_reg;
    logic [NP_W-1:0]       nprod_reg;
    logic [NP_W-1:0]       acc_reg;
    logic [NB_W-1:0]       q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [M_W-1:0] m0_reg;

    logic                  take;
    logic signed [15:0]    v_clamp;
    logic signed [16:0]    off17;
    logic signed [16:0]    range17;
    logic                  range_pos;
    logic [NB_W-1:0]       n_cur;
    logic [NP_W-1:0]       trial;
    logic                  ge;
    logic [1:0]            mode_now;
    logic [NB_W-1:0]       hot_sat;

    assign s_axis_tready = !hold_valid_reg;
    assign take = (state_reg == ST_IDLE) && hold_valid_reg;

    always_comb
    begin
        if (hold_sample_reg < cfg.bin_min)
            v_clamp = cfg.bin_min;
        else if (hold_sample_reg > cfg.bin_max)
            v_clamp = cfg.bin_max;
        else
            v_clamp = hold_sample_reg;

        off17     = {v_reg[15], v_reg} - {cfg.bin_min[15], cfg.bin_min};
        range17   = {cfg.bin_max[15], cfg.bin_max} - {cfg.bin_min[15], cfg.bin_min};
        range_pos = !range17[16] && (range17 != 17'sd0);
        n_cur     = n_eff(cfg.num_bins);

        priority if (dcr_reg)
            mode_now = MODE_OUT;
        else if (cfg.bin_sigma == '0)
            mode_now = MODE_HOT;
        else if (!range_pos)
            mode_now = MODE_ZERO;
        else
            mode_now = MODE_GAUSS;

        trial = NP_W'(range_u_reg) << cnt_reg;
        ge    = acc_reg >= trial;

        if (!range_pos_reg)
            hot_sat = '0;
        else if (q_reg >= n_reg)
            hot_sat = n_reg - NB_W'(1);
        else
            hot_sat = q_reg;

        hold_valid_next = hold_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            hold_valid_next = 1'b1;
        else if (take)
            hold_valid_next = 1'b0;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (hold_valid_reg) state_next = ST_MUL;
            ST_MUL:  state_next = ST_M0;
            ST_M0:   state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_PUSH;
            ST_PUSH: if (!full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign push             = (state_reg == ST_PUSH) && !full;
    assign push_entry.mode  = mode_reg;
    assign push_entry.hot   = hot_sat;
    assign push_entry.m0    = m0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            hold_sample_reg <= s_axis_tdata;
        if (take)
        begin
            v_reg   <= v_clamp;
            dcr_reg <= cfg.zero_dcr && (v_clamp == 16'sd0);
        end
        if (state_reg == ST_MUL)
        begin
            nprod_reg     <= NP_W'(off17[15:0]) * NP_W'(n_cur);
            n_reg         <= n_cur;
            range_u_reg   <= range17[15:0];
            range_pos_reg <= range_pos;
            mode_reg      <= mode_now;
        end
        if (state_reg == ST_M0)
        begin
            acc_reg <= nprod_reg;
            q_reg   <= '0;
            cnt_reg <= CNT_W'(NB_W - 1);
            m0_reg  <= $signed({1'b0, nprod_reg, 1'b0}) - $signed(M_W'(range_u_reg));
        end
        if (state_reg == ST_DIV)
        begin
            if (ge)
            begin
                acc_reg <= acc_reg - trial;
                q_reg   <= q_reg | (NB_W'(1) << cnt_reg);
            end
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

### rtl/vbpc_fifo.sv
// Short request queue between the front end and the back end.
// Uses vbpc_pkg for the entry type and depth.
`default_nettype none

module vbpc_fifo import vbpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     valid
);

    localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W = $clog2(QDEPTH + 1);

    q_entry_t        mem_reg [QDEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QC_W'(QDEPTH));
    assign valid     = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QA_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QA_W'(1);
        if (push && !pop)
            count_next = count_reg + QC_W'(1);
        else if (pop && !push)
            count_next = count_reg - QC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

### rtl/vbpc_zq_div.sv
// Pipelined restoring divider, one quotient bit per stage:
// zq = (am << 19) / den, valid while zq < 2^ZQ_W. Uses vbpc_pkg.
`default_nettype none

module vbpc_zq_div import vbpc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [AM_W-1:0] in_am,
    input  div_tag_t        in_tag,
    input  logic [DEN_W-1:0] den,
    output logic            out_valid,
    output logic [ZQ_W-1:0] out_zq,
    output div_tag_t        out_tag
);

    logic [ZQ_W-1:0]  vld_reg;
    logic [REM_W-1:0] rem_reg [ZQ_W];
    logic [ZQ_W-1:0]  q_reg   [ZQ_W];
    div_tag_t         tag_reg [ZQ_W];

    for (genvar s = 0; s < ZQ_W; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] trial;
        logic [ZQ_W-1:0]  q_in;
        div_tag_t         tag_in;
        logic             vld_in;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_in = REM_W'({in_am, {FRAC_SHIFT{1'b0}}});
            assign q_in   = '0;
            assign tag_in = in_tag;
            assign vld_in = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign tag_in = tag_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        assign trial = REM_W'(den) << (ZQ_W - 1 - s);
        assign ge    = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? rem_in - trial : rem_in;
                q_reg[s]   <= ge ? (q_in | (ZQ_W'(1) << (ZQ_W - 1 - s))) : q_in;
                tag_reg[s] <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[ZQ_W-1];
    assign out_zq    = q_reg[ZQ_W-1];
    assign out_tag   = tag_reg[ZQ_W-1];

endmodule

`default_nettype wire

### rtl/vbpc_back.sv
// Back end: walks the bins of each queued request, one per cycle unless the output stalls,
// through the distance divider, squarer and exp table. Uses vbpc_pkg, vbpc_zq_div.
`default_nettype none

module vbpc_back import vbpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  q_entry_t           q_entry,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         out_bin,
    output logic signed [15:0] out_act,
    output logic               out_last
);

    localparam logic [1:0] SEL_OUT   = 2'd0;
    localparam logic [1:0] SEL_ONE   = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;
    localparam logic [1:0] SEL_GAUSS = 2'd3;

    // config-derived terms; the user keeps cfg stable while requests are in flight, unenforced by the block
    logic [NB_W-1:0]    n_reg;
    logic [16:0]        two_r_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W+2:0]   den6_reg;
    logic signed [15:0] outv_reg;
    logic [15:0]        range_u;

    logic                  cur_valid_reg;
    logic [1:0]            cur_mode_reg;
    logic [NB_W-1:0]       cur_hot_reg;
    logic [NB_W-1:0]       bin_reg;
    logic signed [M_W-1:0] m_reg;

    logic            iss_valid_reg;
    logic [AM_W-1:0] iss_am_reg;
    div_tag_t        iss_tag_reg;

    logic            dv;
    logic [ZQ_W-1:0] dz;
    div_tag_t        dtag;

    logic             sq_valid_reg;
    logic [ZQ2_W-1:0] sq_zq2_reg;
    div_tag_t         sq_tag_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_act_reg;
    logic [3:0]         out_bin_reg;
    logic               out_last_reg;

    logic                  en;
    logic                  last_bin;
    logic                  issue;
    logic signed [M_W-1:0] m_abs;
    logic [AM_W-1:0]       am;
    logic                  big;
    logic [1:0]            sel_now;
    logic [P_W-1:0]        kprod;
    logic [K_W-1:0]        kk;
    logic [15:0]           tab_val;
    logic signed [15:0]    act_next;

    assign range_u  = cfg.bin_max - cfg.bin_min;
    assign en       = !out_valid_reg || out_ready;
    assign last_bin = (bin_reg == n_reg - NB_W'(1));
    assign issue    = en && cur_valid_reg;
    assign q_pop    = q_valid && (!cur_valid_reg || (issue && last_bin));

    always_comb
    begin
        m_abs = m_reg[M_W-1] ? -m_reg : m_reg;
        am    = m_abs[AM_W-1:0];
        big   = CMP_W'({am, 7'b0}) >= CMP_W'(den6_reg);

        unique case (cur_mode_reg)
            MODE_OUT:   sel_now = SEL_OUT;
            MODE_HOT:   sel_now = (bin_reg == cur_hot_reg) ? SEL_ONE : SEL_OUT;
            MODE_ZERO:  sel_now = SEL_ZERO;
            MODE_GAUSS: sel_now = big ? SEL_ZERO : SEL_GAUSS;
        endcase

        kprod = P_W'(sq_zq2_reg) * P_W'(EXP_TABLE_DEPTH);
        kk    = kprod[P_W-1:K_SHIFT];
        if (kk < K_W'(EXP_TABLE_DEPTH))
            tab_val = EXP_TAB[kk[TAB_AW-1:0]];
        else
            tab_val = '0;

        act_next = '0;
        unique case (sq_tag_reg.sel)
            SEL_OUT:   act_next = outv_reg;
            SEL_ONE:   act_next = ONE_Q14;
            SEL_ZERO:  act_next = '0;
            SEL_GAUSS: act_next = $signed(tab_val);
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_eff(cfg.num_bins);
        two_r_reg <= {range_u, 1'b0};
        den_reg   <= DEN_W'(cfg.bin_sigma) * DEN_W'(range_u);
        den6_reg  <= (DEN_W + 3)'(den_reg) * (DEN_W + 3)'(6);
        outv_reg  <= cfg.zero_neg ? 16'sd0 : NEG_ONE_Q14;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            iss_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                cur_valid_reg <= 1'b1;
            else if (issue && last_bin)
                cur_valid_reg <= 1'b0;
            if (en)
            begin
                iss_valid_reg <= cur_valid_reg;
                sq_valid_reg  <= dv;
                out_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_mode_reg <= q_entry.mode;
            cur_hot_reg  <= q_entry.hot;
            bin_reg      <= '0;
            m_reg        <= q_entry.m0;
        end
        else if (issue)
        begin
            bin_reg <= bin_reg + NB_W'(1);
            m_reg   <= m_reg - $signed(M_W'(two_r_reg));
        end
        if (en)
        begin
            iss_am_reg       <= am;
            iss_tag_reg.sel  <= sel_now;
            iss_tag_reg.bin  <= 4'(bin_reg);
            iss_tag_reg.last <= last_bin;
            sq_zq2_reg       <= ZQ2_W'(dz) * ZQ2_W'(dz);
            sq_tag_reg       <= dtag;
            out_act_reg      <= act_next;
            out_bin_reg      <= sq_tag_reg.bin;
            out_last_reg     <= sq_tag_reg.last;
        end
    end

    vbpc_zq_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (iss_valid_reg),
        .in_am     (iss_am_reg),
        .in_tag    (iss_tag_reg),
        .den       (den_reg),
        .out_valid (dv),
        .out_zq    (dz),
        .out_tag   (dtag)
    );

    assign out_valid = out_valid_reg;
    assign out_act   = out_act_reg;
    assign out_bin   = out_bin_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### rtl/value_to_bin_population_code.sv
// Top level of the value-to-bin population coder: config registers, front
// end, request queue and back end. Uses vbpc_pkg, vbpc_front, vbpc_fifo, vbpc_back.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[15:0] sample
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[3:0] bin_index,
//           |     |                              | tdata[19:4] activity, tlast last
//  cfg      | in  | cfg_we                       | cfg_index, cfg_data[15:0]
//
// A sample yields num_bins results (0 counts as 1, above 16 as 16), one per cycle
// from the back pipeline while m_axis is not stalled; the front end works through
// clamp, multiply, first distance term, a 5-step bin quotient and the queue push
// for each sample, and its input buffer can take the next sample meanwhile.
// Reset clears all handshake state and loads the register reset values.
// A stall on m_axis freezes the back pipeline; the 2-entry queue lets the
// front end run ahead until it fills, then s_axis_tready drops.
`default_nettype none

module value_to_bin_population_code import vbpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] bin_index, [19:4] activity, [23:20] zero
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               push;
    q_entry_t           push_entry;
    logic               full;
    logic               pop;
    q_entry_t           pop_entry;
    logic               q_valid;
    logic [3:0]         out_bin;
    logic signed [15:0] out_act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_min   <= 16'sd0;
            cfg_reg.bin_max   <= 16'sd256;
            cfg_reg.num_bins  <= 5'd16;
            cfg_reg.bin_sigma <= '0;
            cfg_reg.zero_neg  <= 1'b0;
            cfg_reg.zero_dcr  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIN_MIN:   cfg_reg.bin_min   <= cfg_data;
                REG_BIN_MAX:   cfg_reg.bin_max   <= cfg_data;
                REG_NUM_BINS:  cfg_reg.num_bins  <= cfg_data[4:0];
                REG_BIN_SIGMA: cfg_reg.bin_sigma <= cfg_data[SIG_W-1:0];
                REG_ZERO_NEG:  cfg_reg.zero_neg  <= cfg_data[0];
                REG_ZERO_DCR:  cfg_reg.zero_dcr  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    vbpc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_entry    (push_entry),
        .full          (full)
    );

    vbpc_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .valid      (q_valid)
    );

    vbpc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_bin   (out_bin),
        .out_act   (out_act),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_act, out_bin};

endmodule

`default_nettype wire

### tb/tb_value_to_bin_population_code.sv
// Testbench for value_to_bin_population_code: directed and random samples under many
// register settings, checked result by result against an in-bench bin coder.
// Depends on rtl/vbpc_pkg.sv and rtl/value_to_bin_population_code.sv.
module tb_value_to_bin_population_code;
    import vbpc_pkg::*;

    localparam int  SETTLE_CYCLES = 40;
    localparam int  RUN_LIMIT     = 1000000;
    localparam longint ZQ_CUTOFF  = 64'd6 << 12;

    typedef struct packed {
        logic [3:0]         bin;
        logic signed [15:0] activity;
        logic               last;
    } bin_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [3:0] bin_index, [19:4] activity, [23:20] zero
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    cfg_t        coder_cfg;
    logic [15:0] gauss_lut [EXP_TABLE_DEPTH];
    bin_result_t pending_bins [$];
    int          errors = 0;
    int          cycle_count = 0;
    int          rx_hold = 0;
    int          rx_stall = 0;
    bit          steady = 1'b0;

    value_to_bin_population_code dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic cfg_t make_cfg(input int mn, input int mx, input int nb,
                                      input int sig, input int neg, input int dcr);
        cfg_t c;
        c.bin_min   = 16'(mn);
        c.bin_max   = 16'(mx);
        c.num_bins  = 5'(nb);
        c.bin_sigma = 12'(sig);
        c.zero_neg  = 1'(neg);
        c.zero_dcr  = 1'(dcr);
        return c;
    endfunction

    // population code for one sample under the current register values
    function automatic void predict_bins(input logic signed [15:0] smp);
        longint      s, mn, mx, v, n, range, off, hot, m, am, den, zq, k;
        logic signed [15:0] outv;
        logic signed [15:0] act;
        bit          dcr;
        bin_result_t r;
        s   = smp;
        mn  = $signed(coder_cfg.bin_min);
        mx  = $signed(coder_cfg.bin_max);
        v   = (s < mn) ? mn : ((s > mx) ? mx : s);
        n   = coder_cfg.num_bins;
        if (n < 1)
            n = 1;
        if (n > NUM_BINS)
            n = NUM_BINS;
        range = mx - mn;
        off   = v - mn;
        outv  = coder_cfg.zero_neg ? 16'sd0 : -16'sd16384;
        dcr   = coder_cfg.zero_dcr && (v == 0);
        hot   = 0;
        if (range > 0)
        begin
            hot = (off * n) / range;
            if (hot >= n)
                hot = n - 1;
        end
        for (longint i = 0; i < n; i++)
        begin
            if (dcr)
                act = outv;
            else if (coder_cfg.bin_sigma == 0)
                act = (i == hot) ? 16'sd16384 : outv;
            else if (range <= 0)
                act = 16'sd0;
            else
            begin
                m   = 2 * off * n - (2 * i + 1) * range;
                am  = (m < 0) ? -m : m;
                den = longint'(coder_cfg.bin_sigma) * range;
                zq  = (am <<< 19) / den;
                if (zq >= ZQ_CUTOFF)
                    act = 16'sd0;
                else
                begin
                    k   = (zq * zq * EXP_TABLE_DEPTH) >>> 29;
                    act = (k < EXP_TABLE_DEPTH) ? gauss_lut[k] : 16'sd0;
                end
            end
            r.bin      = 4'(i);
            r.activity = act;
            r.last     = (i == n - 1);
            pending_bins.push_back(r);
        end
    endfunction

    task automatic send_sample(input logic signed [15:0] smp);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_bins(smp);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // first writes junk to an unused index; narrow registers get junk in the unused upper data bits
    task automatic apply_config(input cfg_t c);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ZERO_DCR + 3'($urandom_range(1, 2));
        cfg_data  <= 16'($urandom);
        @(negedge clk);
        cfg_index <= REG_BIN_MIN;
        cfg_data  <= c.bin_min;
        @(negedge clk);
        cfg_index <= REG_BIN_MAX;
        cfg_data  <= c.bin_max;
        @(negedge clk);
        cfg_index <= REG_NUM_BINS;
        cfg_data  <= {11'($urandom), c.num_bins};
        @(negedge clk);
        cfg_index <= REG_BIN_SIGMA;
        cfg_data  <= {4'($urandom), c.bin_sigma};
        @(negedge clk);
        cfg_index <= REG_ZERO_NEG;
        cfg_data  <= {15'($urandom), c.zero_neg};
        @(negedge clk);
        cfg_index <= REG_ZERO_DCR;
        cfg_data  <= {15'($urandom), c.zero_dcr};
        @(negedge clk);
        cfg_we    <= 1'b0;
        coder_cfg = c;
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'sh00FF);
        send_sample(16'sh0100);
        send_sample(16'shFFFF);
        send_sample(16'sh0080);
    endtask

    task automatic test_special_cases();
        // gaussian, exact zero is do-not-care
        apply_config(make_cfg(-512, 512, 8, 256, 0, 1));
        send_sample(16'sh0000);
        send_sample(16'sh0040);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        // zero bin count acts as one, out-of-bin value zero
        apply_config(make_cfg(-256, 256, 0, 0, 1, 0));
        send_sample(16'sh0000);
        send_sample(16'sh0064);
        // oversized bin count, widest sigma, full range
        apply_config(make_cfg(-32768, 32767, 31, 4095, 0, 0));
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        // inverted range
        apply_config(make_cfg(256, -256, 4, 0, 0, 0));
        send_sample(16'sh0000);
        send_sample(16'sh012C);
        apply_config(make_cfg(256, -256, 4, 1, 0, 0));
        send_sample(16'sh0000);
        // empty range
        apply_config(make_cfg(100, 100, 5, 0, 1, 0));
        send_sample(16'sh0064);
        // narrowest sigma
        apply_config(make_cfg(0, 4096, 16, 1, 0, 0));
        send_sample(16'sh0800);
        send_sample(16'sh0834);
    endtask

    // output held off long enough for the input side to back up
    task automatic test_input_stall();
        apply_config(make_cfg(-1024, 1024, 16, 128, 0, 0));
        steady  = 1'b1;
        rx_hold = 300;
        repeat (14) send_sample(16'($urandom));
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_random_configs();
        int mn, mx, nb, sig, smp;
        for (int phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    mn = -32768;
                    mx = 32767;
                end
                1:
                begin
                    mn = int'($urandom_range(0, 65535)) - 32768;
                    mx = mn - int'($urandom_range(0, 300));
                    if (mx < -32768)
                        mx = -32768;
                end
                default:
                begin
                    mn = int'($urandom_range(0, 60000)) - 32768;
                    mx = mn + int'($urandom_range(1, ($urandom_range(0, 1) == 1) ?
                                                     64 : 32767 - mn));
                end
            endcase
            nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0, 1, 2: sig = 0;
                3:       sig = 4095;
                4:       sig = $urandom_range(1, 16);
                default: sig = $urandom_range(32, 1024);
            endcase
            apply_config(make_cfg(mn, mx, nb, sig, $urandom_range(0, 1),
                                  $urandom_range(0, 1)));
            steady = (phase == 5);
            for (int j = 0; j < 32; j++)
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2: smp = int'($urandom_range(0, 65535)) - 32768;
                    3, 4, 5: smp = (mx > mn) ? mn + int'($urandom_range(0, mx - mn)) : mn;
                    6:       smp = 0;
                    default: smp = (($urandom_range(0, 1) == 1) ? mn : mx)
                                   + int'($urandom_range(0, 4)) - 2;
                endcase
                send_sample(16'(smp));
                if (j == 16 && phase % 3 == 0)
                    wait_idle();
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_result
        bin_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bins.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual bin %0d activity %0d",
                         $time, m_axis_tdata[3:0], $signed(m_axis_tdata[19:4]));
                errors++;
            end
            else
            begin
                want = pending_bins.pop_front();
                if (m_axis_tdata[3:0] !== want.bin)
                begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, want.bin, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[19:4] !== want.activity)
                begin
                    $display("%0t: bin %0d activity expected %0d actual %0d", $time,
                             want.bin, want.activity, $signed(m_axis_tdata[19:4]));
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: bin %0d last expected %0b actual %0b",
                             $time, want.bin, want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin : main
        logic [63:0]        step_y, term, ratio, acc;
        logic signed [63:0] series;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_BIN_MIN;
        cfg_data      = '0;
        coder_cfg     = make_cfg(0, 256, 16, 0, 0, 0);

        // exp(-u) over u in [0,16): Q31 decay ratio, then a rounded geometric walk
        step_y = (64'd16 << 31) / 64'(EXP_TABLE_DEPTH);
        term   = 64'd1 << 31;
        series = $signed(term);
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * step_y) >> 31) / 64'(k);
            if (k % 2 == 1)
                series = series - $signed(term);
            else
                series = series + $signed(term);
        end
        ratio = series;
        acc   = 64'd1 << 31;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
        begin
            gauss_lut[k] = 16'((acc + (64'd1 << 16)) >> 17);
            acc = (acc * ratio + (64'd1 << 30)) >> 31;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_input_stall();
        test_random_configs();
        wait_idle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
